// ===== sv/psrs_pkg.sv =====
// Package for the polyline straight-run splitter: sizes, codes, control word, helpers.
package psrs_pkg;

    localparam int MAX_RUN = 64;
    localparam int RUN_AW  = $clog2(MAX_RUN);
    localparam int LEN_W   = $clog2(MAX_RUN + 1);
    localparam int OP_W    = 34;
    localparam int PROD_W  = 2 * OP_W;
    localparam int RHS_W   = 66;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT_A,
        ST_DOT_B,
        ST_DOT_C,
        ST_DOT_D,
        ST_LEN_A,
        ST_LEN_B,
        ST_LEN_C,
        ST_LEN_D,
        ST_RD,
        ST_Q_A,
        ST_Q_B,
        ST_Q_C,
        ST_Q_D,
        ST_Q_E,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        MS_DOT_X,
        MS_DOT_Y,
        MS_DXDX,
        MS_DYDY,
        MS_TOL,
        MS_RHS,
        MS_CROSS_A,
        MS_CROSS_B,
        MS_EXEX,
        MS_EYEY,
        MS_CSQ
    } t_mul_sel;

    typedef enum logic [1:0] {
        AO_HOLD,
        AO_LOAD,
        AO_ADD,
        AO_SUB
    } t_acc_op;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     ld_len2;
        logic     ld_rhs;
        logic     rd_en;
        logic     k_inc;
        logic     append;
        logic     brk;
        logic     brk_forced;
        logic     out_load;
    } t_ctrl;

    // 17-bit signed difference of two 16-bit signed coordinates
    function automatic logic signed [16:0] f_diff(input logic [15:0] a, input logic [15:0] b);
        f_diff = $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    function automatic logic signed [OP_W-1:0] f_ext(input logic signed [16:0] v);
        f_ext = {{(OP_W - 17){v[16]}}, v};
    endfunction

endpackage

// ===== sv/polyline_straight_run_splitter.sv =====
// Top level: polyline straight-run splitter with one shared multiplier under a sequencer.
//
// Points enter one word at a time (x, y, first-point flag); a word is emitted with the
// index of each new straight run start. The first and second point of a run need no
// multiplier work, and a first point also posts a result. Every later point is checked by
// one shared 34x34 multiplier: first the turn-back test, then the set-up of the segment
// length and tolerance products, then a check of each inner point (with a further
// squared-cross step, ST_Q_E, when the segment is not degenerate); a break posts its result.
// The input is not ready while a point is at work; a posted result waits in the output
// register and holds up the input only when a further result must be posted before it
// is taken. The run store is a 64-entry memory, one read or write a cycle; entry 0 (the
// anchor) and the last two points live in registers.
module polyline_straight_run_splitter
    import psrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] x, [31:16] y
    input  logic        s_axis_tuser,   // [0] first_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] run_start
    output logic        m_axis_tuser    // [0] forced
);

    t_state r_state, n_state;
    t_ctrl  ctl;

    logic [15:0]              r_tol;
    logic [31:0]              r_anchor, r_last, r_prev, r_p, r_q;
    logic [LEN_W-1:0]         r_len;
    logic [15:0]              r_idx, r_cur;
    logic [RUN_AW-1:0]        r_k;
    logic signed [PROD_W-1:0] r_prod, r_acc;
    logic [31:0]              r_tol2;
    logic                     r_nondeg;
    logic [RHS_W-1:0]         r_rhs;
    logic [15:0]              r_res_start, r_out_start;
    logic                     r_res_forced, r_out_forced, r_out_valid;
    logic [31:0]              r_mem [MAX_RUN];

    logic                     w_in_acc, w_first;
    logic [15:0]              w_cur;
    logic signed [OP_W-1:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0] w_cmag;
    logic                     w_far_deg, w_far_big, w_far, w_judge, w_last_k, w_full;
    logic                     w_dot_pos;
    logic                     w_we;
    logic [RUN_AW-1:0]        w_waddr;
    logic [31:0]              w_wdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_first       = s_axis_tuser;
    assign w_cur         = w_first ? 16'd0 : r_idx;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_start;
    assign m_axis_tuser  = r_out_forced;

    assign w_cmag    = r_acc[PROD_W-1] ? -r_acc : r_acc;
    assign w_far_deg = $unsigned(r_acc[RHS_W-1:0]) > {{(RHS_W - 32){1'b0}}, r_tol2};
    assign w_far_big = $unsigned(r_prod[RHS_W-1:0]) > r_rhs;
    assign w_far     = (r_state == ST_Q_E) ? w_far_big : w_far_deg;
    assign w_judge   = (r_state == ST_Q_E) || ((r_state == ST_Q_D) && !r_nondeg);
    assign w_last_k  = ({1'b0, r_k} + LEN_W'(1)) == r_len;
    assign w_full    = r_len >= LEN_W'(MAX_RUN);
    assign w_dot_pos = !r_acc[PROD_W-1] && (r_acc != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    priority if (w_first)                n_state = ST_DONE;
                    else if (r_len <= LEN_W'(1))         n_state = ST_IDLE;
                    else                                 n_state = ST_DOT_A;
                end
            end
            ST_DOT_A: n_state = ST_DOT_B;
            ST_DOT_B: n_state = ST_DOT_C;
            ST_DOT_C: n_state = ST_DOT_D;
            ST_DOT_D: n_state = w_dot_pos ? ST_LEN_A : ST_DONE;
            ST_LEN_A: n_state = ST_LEN_B;
            ST_LEN_B: n_state = ST_LEN_C;
            ST_LEN_C: n_state = ST_LEN_D;
            ST_LEN_D: n_state = ST_Q_A;
            ST_RD:    n_state = ST_Q_A;
            ST_Q_A:   n_state = ST_Q_B;
            ST_Q_B:   n_state = ST_Q_C;
            ST_Q_C:   n_state = ST_Q_D;
            ST_Q_D, ST_Q_E: begin
                if (!w_judge)       n_state = ST_Q_E;
                else if (w_far)     n_state = ST_DONE;
                else if (w_last_k)  n_state = w_full ? ST_DONE : ST_IDLE;
                else                n_state = ST_RD;
            end
            ST_DONE: n_state = (!r_out_valid || m_axis_tready) ? ST_IDLE : ST_DONE;
        endcase
    end

    // control outputs
    always_comb begin
        ctl = '0;
        ctl.mul_sel = MS_DOT_X;
        ctl.acc_op  = AO_HOLD;
        unique case (r_state)
            ST_IDLE: ;
            ST_DOT_A: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MS_DOT_X;
            end
            ST_DOT_B: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MS_DOT_Y;
                ctl.acc_op = AO_LOAD;
            end
            ST_DOT_C: ctl.acc_op = AO_ADD;
            ST_DOT_D: begin
                if (w_dot_pos) begin
                    ctl.mul_en = 1'b1;
                    ctl.mul_sel = MS_DXDX;
                end else begin
                    ctl.brk = 1'b1;
                end
            end
            ST_LEN_A: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MS_DYDY;
                ctl.acc_op = AO_LOAD;
            end
            ST_LEN_B: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MS_TOL;
                ctl.acc_op = AO_ADD;
            end
            ST_LEN_C: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MS_RHS;
                ctl.ld_len2 = 1'b1;
            end
            ST_LEN_D: begin
                ctl.ld_rhs = 1'b1;
                ctl.rd_en = 1'b1;
            end
            ST_RD: ctl.rd_en = 1'b1;
            ST_Q_A: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = r_nondeg ? MS_CROSS_A : MS_EXEX;
            end
            ST_Q_B: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = r_nondeg ? MS_CROSS_B : MS_EYEY;
                ctl.acc_op = AO_LOAD;
            end
            ST_Q_C: ctl.acc_op = r_nondeg ? AO_SUB : AO_ADD;
            ST_Q_D, ST_Q_E: begin
                if (!w_judge) begin
                    ctl.mul_en = 1'b1;
                    ctl.mul_sel = MS_CSQ;
                end else if (w_far) begin
                    ctl.brk = 1'b1;
                end else if (w_last_k) begin
                    ctl.brk        = w_full;
                    ctl.brk_forced = w_full;
                    ctl.append     = !w_full;
                end else begin
                    ctl.k_inc = 1'b1;
                end
            end
            ST_DONE: ctl.out_load = !r_out_valid || m_axis_tready;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (ctl.mul_sel)
            MS_DOT_X: begin
                w_ma = f_ext(f_diff(r_last[15:0], r_prev[15:0]));
                w_mb = f_ext(f_diff(r_p[15:0], r_last[15:0]));
            end
            MS_DOT_Y: begin
                w_ma = f_ext(f_diff(r_last[31:16], r_prev[31:16]));
                w_mb = f_ext(f_diff(r_p[31:16], r_last[31:16]));
            end
            MS_DXDX: begin
                w_ma = f_ext(f_diff(r_p[15:0], r_anchor[15:0]));
                w_mb = w_ma;
            end
            MS_DYDY: begin
                w_ma = f_ext(f_diff(r_p[31:16], r_anchor[31:16]));
                w_mb = w_ma;
            end
            MS_TOL: begin
                w_ma = {{(OP_W - 16){1'b0}}, r_tol};
                w_mb = w_ma;
            end
            MS_RHS: begin
                w_ma = {{(OP_W - 32){1'b0}}, r_prod[31:0]};
                w_mb = {1'b0, r_acc[OP_W-2:0]};
            end
            MS_CROSS_A: begin
                w_ma = f_ext(f_diff(r_p[15:0], r_anchor[15:0]));
                w_mb = f_ext(f_diff(r_q[31:16], r_anchor[31:16]));
            end
            MS_CROSS_B: begin
                w_ma = f_ext(f_diff(r_p[31:16], r_anchor[31:16]));
                w_mb = f_ext(f_diff(r_q[15:0], r_anchor[15:0]));
            end
            MS_EXEX: begin
                w_ma = f_ext(f_diff(r_q[15:0], r_anchor[15:0]));
                w_mb = w_ma;
            end
            MS_EYEY: begin
                w_ma = f_ext(f_diff(r_q[31:16], r_anchor[31:16]));
                w_mb = w_ma;
            end
            MS_CSQ: begin
                w_ma = w_cmag[OP_W-1:0];
                w_mb = w_ma;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // run store write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = RUN_AW'(1);
        w_wdata = r_p;
        if (w_in_acc && !w_first && (r_len == LEN_W'(1))) begin
            w_we    = 1'b1;
            w_wdata = s_axis_tdata;
        end else if (ctl.brk) begin
            w_we    = 1'b1;
        end else if (ctl.append) begin
            w_we    = 1'b1;
            w_waddr = r_len[RUN_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (ctl.rd_en) begin
            r_q <= r_mem[r_k];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tol       <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                r_idx <= w_cur + 16'd1;
                if (w_first || (r_len == '0)) begin
                    r_len <= LEN_W'(1);
                end else if (r_len == LEN_W'(1)) begin
                    r_len <= LEN_W'(2);
                end
            end else if (ctl.brk) begin
                r_len <= LEN_W'(2);
            end else if (ctl.append) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p   <= s_axis_tdata;
            r_cur <= w_cur;
            if (w_first || (r_len == '0)) begin
                r_anchor     <= s_axis_tdata;
                r_last       <= s_axis_tdata;
                r_res_start  <= '0;
                r_res_forced <= 1'b0;
            end else if (r_len == LEN_W'(1)) begin
                r_prev <= r_last;
                r_last <= s_axis_tdata;
            end
        end
        if (ctl.brk) begin
            r_anchor     <= r_last;
            r_prev       <= r_last;
            r_last       <= r_p;
            r_res_start  <= r_cur - 16'd1;
            r_res_forced <= ctl.brk_forced;
        end else if (ctl.append) begin
            r_prev <= r_last;
            r_last <= r_p;
        end
        if (ctl.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        unique case (ctl.acc_op)
            AO_HOLD: ;
            AO_LOAD: r_acc <= r_prod;
            AO_ADD:  r_acc <= r_acc + r_prod;
            AO_SUB:  r_acc <= r_acc - r_prod;
        endcase
        if (ctl.ld_len2) begin
            r_tol2   <= r_prod[31:0];
            r_nondeg <= (r_acc != '0);
            r_k      <= RUN_AW'(1);
        end else if (ctl.k_inc) begin
            r_k <= r_k + RUN_AW'(1);
        end
        if (ctl.ld_rhs) begin
            r_rhs <= r_prod[RHS_W-1:0];
        end
        if (ctl.out_load) begin
            r_out_start  <= r_res_start;
            r_out_forced <= r_res_forced;
        end
    end

endmodule

// ===== sv/psrs_checker.sv =====
// Port checker for the polyline straight-run splitter, bound to the top level.
module psrs_checker
    import psrs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word dropped or changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not clear the block");

    a_first_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("ready during first point result");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=>
            ##1 m_axis_tvalid && (m_axis_tdata == 16'd0) && !m_axis_tuser)
        else $error("first point did not yield run start zero");

endmodule

bind polyline_straight_run_splitter psrs_checker u_psrs_checker (.*);
